// ===== rtl/smwd_pkg.sv =====
// ----------------------------------------------------------------------------
// smwd_pkg
// Shared types and constants for the SPI master-out word decoder.
// ----------------------------------------------------------------------------
package smwd_pkg;

  localparam int LEVELS_W     = 8;
  localparam int TIME_W       = 48;
  localparam int VALUE_W      = 16;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_INDEX_W  = 3;

  localparam int CHANNELS_DEF      = 8;
  localparam int MAX_WORD_BITS_DEF = 16;

  localparam int MIN_WORD_BITS  = 4;
  localparam int FALLBACK_BITS  = 8;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLOCK_CHANNEL  = 3'd0,
    CFG_DATA_CHANNEL   = 3'd1,
    CFG_SELECT_CHANNEL = 3'd2,
    CFG_BUS_MODE       = 3'd3,
    CFG_BIT_ORDER      = 3'd4,
    CFG_WORD_BITS      = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] clock_channel;
    logic [2:0] data_channel;
    logic [3:0] select_channel;
    logic [1:0] bus_mode;
    logic       bit_order;    // 1: MSB shifted in first
    logic [4:0] word_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    clock_channel:  3'd0,
    data_channel:   3'd1,
    select_channel: 4'd2,
    bus_mode:       2'd0,
    bit_order:      1'b1,
    word_bits:      5'd8
  };

  typedef struct packed {
    logic              emit;
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
  } result_t;

endpackage

// ===== rtl/smwd_core.sv =====
// ----------------------------------------------------------------------------
// smwd_core
// Decoder state and the per-sample edge detect, shift and count logic.
// ----------------------------------------------------------------------------
module smwd_core #(
  parameter int CHANNELS      = smwd_pkg::CHANNELS_DEF,
  parameter int MAX_WORD_BITS = smwd_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  smwd_pkg::cfg_t                cfg,
  input  logic [smwd_pkg::LEVELS_W-1:0] levels,
  input  logic [smwd_pkg::TIME_W-1:0]   sample_time,
  input  logic                          window_start,
  output smwd_pkg::result_t             res
);
  import smwd_pkg::*;

  localparam int CW = $clog2(MAX_WORD_BITS + 1);

  logic [LEVELS_W-1:0]      prev_levels;
  logic                     selected;
  logic [CW-1:0]            bit_cnt;
  logic [MAX_WORD_BITS-1:0] shift_reg;
  logic [TIME_W-1:0]        first_time;

  logic                     selected_next;
  logic [CW-1:0]            bit_cnt_next;
  logic [MAX_WORD_BITS-1:0] shift_reg_next;
  logic [TIME_W-1:0]        first_time_next;

  logic                     cs_en;
  logic [2:0]               cs_idx;
  logic [LEVELS_W-1:0]      changed;
  logic                     sck_lvl;
  logic                     data_lvl;
  logic                     on_rise;
  logic                     wb_ok;
  logic [CW-1:0]            word_len;
  logic [CW-1:0]            count_inc;
  logic [MAX_WORD_BITS-1:0] base_shift;
  logic [MAX_WORD_BITS-1:0] shifted;
  logic [TIME_W-1:0]        start_time;
  logic [31:0]              shifted_wide;

  assign cs_en    = (cfg.select_channel < 4'(CHANNELS)) && !cfg.select_channel[3];
  assign cs_idx   = cfg.select_channel[2:0];
  assign changed  = prev_levels ^ levels;
  assign sck_lvl  = levels[cfg.clock_channel];
  assign data_lvl = levels[cfg.data_channel];
  // modes 0 and 3 take data on the rising clock edge
  assign on_rise  = (cfg.bus_mode[1] == cfg.bus_mode[0]);
  assign wb_ok    = (cfg.word_bits >= 5'(MIN_WORD_BITS)) &&
                    ({1'b0, cfg.word_bits} <= 6'(MAX_WORD_BITS));
  assign word_len = wb_ok ? CW'(cfg.word_bits) : CW'(FALLBACK_BITS);
  assign count_inc = bit_cnt + 1'b1;

  // first bit of a word restarts the shift value and the start time
  assign base_shift = (bit_cnt == '0) ? '0 : shift_reg;
  assign start_time = (bit_cnt == '0) ? sample_time : first_time;

  always_comb begin
    if (cfg.bit_order) begin
      shifted = {base_shift[MAX_WORD_BITS-2:0], data_lvl};
    end else begin
      for (int i = 0; i < MAX_WORD_BITS; i++) begin
        shifted[i] = base_shift[i] | (data_lvl && (bit_cnt == CW'(i)));
      end
    end
  end

  assign shifted_wide = 32'(shifted);

  always_comb begin
    selected_next   = selected;
    bit_cnt_next    = bit_cnt;
    shift_reg_next  = shift_reg;
    first_time_next = first_time;
    res.emit        = 1'b0;
    res.value       = shifted_wide[VALUE_W-1:0];
    res.start_time  = start_time;
    res.end_time    = sample_time;
    if (window_start) begin
      selected_next  = !cs_en || !levels[cs_idx];
      bit_cnt_next   = '0;
      shift_reg_next = '0;
    end else if (cfg.clock_channel != cfg.data_channel) begin
      if (cs_en && changed[cs_idx]) begin
        // select edge wins over a clock edge in the same sample
        selected_next  = !levels[cs_idx];
        bit_cnt_next   = '0;
        shift_reg_next = '0;
      end else if ((!cs_en || selected) && changed[cfg.clock_channel] &&
                   (sck_lvl == on_rise)) begin
        shift_reg_next  = shifted;
        first_time_next = start_time;
        if (count_inc >= word_len) begin
          res.emit     = 1'b1;
          bit_cnt_next = '0;
        end else begin
          bit_cnt_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      selected    <= 1'b0;
      bit_cnt     <= '0;
      shift_reg   <= '0;
      first_time  <= '0;
    end else if (fire) begin
      prev_levels <= levels;
      selected    <= selected_next;
      bit_cnt     <= bit_cnt_next;
      shift_reg   <= shift_reg_next;
      first_time  <= first_time_next;
    end
  end

endmodule

// ===== rtl/spi_mosi_word_decoder.sv =====
// ----------------------------------------------------------------------------
// spi_mosi_word_decoder
// Decodes SPI master-out words from a stream of logic-capture samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one capture sample per
//   transaction: levels of all channels, its timestamp and a window_start
//   flag. Output channel (out_valid/out_ready) carries one decoded word per
//   transaction with the times of its first and last sampled bit. Most
//   samples produce no word.
//   A sample accepted into the input register is decoded from there and
//   its word is registered in the result register before it can be taken.
//   Throughput: one sample per cycle while no word stalls; the input
//   register holds one sample and the result register one word, so a
//   new sample is taken while a word waits in the result register.
//   When out_ready is low with a word pending, the sample in the input
//   register waits and in_ready drops once that register is full.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at the
//   next edge and belong between samples with the block drained.
//   Synchronous reset restores the register defaults, clears the decoder
//   state and empties both pipeline registers.
// ----------------------------------------------------------------------------
module spi_mosi_word_decoder #(
  parameter int CHANNELS      = smwd_pkg::CHANNELS_DEF,
  parameter int MAX_WORD_BITS = smwd_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [smwd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [smwd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [smwd_pkg::LEVELS_W-1:0]    levels,
  input  logic [smwd_pkg::TIME_W-1:0]      sample_time,
  input  logic                             window_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [smwd_pkg::VALUE_W-1:0]     word_value,
  output logic [smwd_pkg::TIME_W-1:0]      word_start_time,
  output logic [smwd_pkg::TIME_W-1:0]      word_end_time
);
  import smwd_pkg::*;

  cfg_t                cfg;
  logic                s1_valid;
  logic [LEVELS_W-1:0] s1_levels;
  logic [TIME_W-1:0]   s1_time;
  logic                s1_start;
  logic                advance;
  logic                fire;
  result_t             res;

  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CLOCK_CHANNEL:  cfg.clock_channel  <= cfg_data[2:0];
        CFG_DATA_CHANNEL:   cfg.data_channel   <= cfg_data[2:0];
        CFG_SELECT_CHANNEL: cfg.select_channel <= cfg_data[3:0];
        CFG_BUS_MODE:       cfg.bus_mode       <= cfg_data[1:0];
        CFG_BIT_ORDER:      cfg.bit_order      <= cfg_data[0];
        CFG_WORD_BITS:      cfg.word_bits      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_levels <= levels;
      s1_time   <= sample_time;
      s1_start  <= window_start;
    end
  end

  smwd_core #(
    .CHANNELS      (CHANNELS),
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cfg          (cfg),
    .levels       (s1_levels),
    .sample_time  (s1_time),
    .window_start (s1_start),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      word_value      <= res.value;
      word_start_time <= res.start_time;
      word_end_time   <= res.end_time;
    end
  end

endmodule

// ===== rtl/smwd_checker.sv =====
// ----------------------------------------------------------------------------
// smwd_checker
// Port-level checks for the SPI master-out word decoder.
// ----------------------------------------------------------------------------
module smwd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [smwd_pkg::VALUE_W-1:0]     word_value,
  input logic [smwd_pkg::TIME_W-1:0]      word_start_time,
  input logic [smwd_pkg::TIME_W-1:0]      word_end_time
);

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // reset empties the input register
  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low right after reset");

  // input only backs up behind a pending word
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled word");

  // a stalled word holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_value) &&
      $stable(word_start_time) && $stable(word_end_time))
    else $error("stalled word changed");

endmodule

bind spi_mosi_word_decoder smwd_checker u_smwd_checker (.*);
